>>> sv/pitch_shift_resampler_macros.svh
// Assertion macros for the pitch shift resampler checker.
// No dependencies; included by the checker file.
`ifndef PITCH_SHIFT_RESAMPLER_MACROS_SVH
`define PITCH_SHIFT_RESAMPLER_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define PSR_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pitch_shift_resampler: assertion failed");

// Consequent checked from the cycle after the antecedent.
`define PSR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pitch_shift_resampler: assertion failed");

`endif

>>> sv/psr_pkg.sv
// Shared types, constants and sine helper for the pitch shift resampler.
// No dependencies.
`timescale 1ns / 1ps

package psr_pkg;

  localparam int RING_DEPTH_DEF       = 256;
  localparam int SINE_TABLE_DEPTH_DEF = 256;

  localparam int CFG_DW = 16;

  localparam logic [8:0]  PITCH_FACTOR_RST  = 9'd384;
  localparam logic [15:0] VIBRATO_STEP_RST  = 16'd655;
  localparam logic [15:0] VIBRATO_DEPTH_RST = 16'd19661;
  localparam logic [9:0]  OUTPUT_GAIN_RST   = 10'd307;

  typedef enum logic [1:0] {
    REG_PITCH_FACTOR,
    REG_VIBRATO_STEP,
    REG_VIBRATO_DEPTH,
    REG_OUTPUT_GAIN
  } cfg_reg_t;

  typedef struct packed {
    logic [8:0]  pitch_factor;
    logic [15:0] vibrato_step;
    logic [15:0] vibrato_depth;
    logic [9:0]  output_gain;
  } psr_cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } psr_pass_stat_t;

  typedef enum logic [1:0] {
    PASS_IDLE,
    PASS_ISSUE,
    PASS_DRAIN
  } pass_state_t;

  // Sine of a Q0.16 turn in Q1.15, odd polynomial on the folded quarter wave.
  function automatic logic signed [15:0] sine_of_turn(input logic [15:0] q);
    logic [31:0] x;
    logic [31:0] x2;
    logic [31:0] t;
    logic [31:0] p;
    logic signed [15:0] ys;
    p = {18'b0, q[13:0]};
    x = q[14] ? ((32'd16384 - p) << 1) : (p << 1);
    x2 = (x * x) >> 15;
    t = (x2 * 32'd2463) >> 15;
    t = 32'd21167 - t;
    t = (x2 * t) >> 15;
    t = 32'd51472 - t;
    t = (x * t) >> 15;
    if (t > 32'd32767) begin
      t = 32'd32767;
    end
    ys = signed'(t[15:0]);
    return q[15] ? -ys : ys;
  endfunction

endpackage

>>> sv/psr_sine_rom.sv
// Sine lookup ROM with a registered read, built at elaboration.
// Depends on psr_pkg for the sine polynomial.
`timescale 1ns / 1ps

module psr_sine_rom
  import psr_pkg::*;
#(
  parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF
) (
  input  logic                                  clk,
  input  logic [$clog2(SINE_TABLE_DEPTH)-1:0]   addr,
  output logic signed [15:0]                    data
);

  typedef logic signed [15:0] sine_tbl_t [SINE_TABLE_DEPTH];

  function automatic sine_tbl_t build_table();
    sine_tbl_t   tbl;
    int          k;
    int unsigned q;
    for (k = 0; k < SINE_TABLE_DEPTH; k++) begin
      q = (k * 65536) / SINE_TABLE_DEPTH;
      tbl[k] = sine_of_turn(q[15:0]);
    end
    return tbl;
  endfunction

  localparam sine_tbl_t SINE_TBL = build_table();

  always_ff @(posedge clk) begin
    data <= SINE_TBL[addr];
  end

endmodule

>>> sv/psr_ring.sv
// Input sample ring: one write port and two registered read ports.
// Depends on psr_pkg for the default depth.
`timescale 1ns / 1ps

module psr_ring
  import psr_pkg::*;
#(
  parameter int RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            we,
  input  logic [$clog2(RING_DEPTH)-1:0]   waddr,
  input  logic signed [11:0]              wdata,
  input  logic [$clog2(RING_DEPTH)-1:0]   raddr_a,
  input  logic [$clog2(RING_DEPTH)-1:0]   raddr_b,
  output logic signed [11:0]              rdata_a,
  output logic signed [11:0]              rdata_b
);

  logic signed [11:0] mem [RING_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

>>> sv/psr_pass.sv
// Block pass engine: vibrato phase step, ring interpolation, gain and saturation,
// one store position per cycle. Depends on psr_pkg and psr_sine_rom.
`timescale 1ns / 1ps

module psr_pass
  import psr_pkg::*;
#(
  parameter int RING_DEPTH       = RING_DEPTH_DEF,
  parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            kick,
  input  psr_cfg_t                        cfg,
  output psr_pass_stat_t                  stat,
  output logic [$clog2(RING_DEPTH)-1:0]   ring_raddr_a,
  output logic [$clog2(RING_DEPTH)-1:0]   ring_raddr_b,
  input  logic signed [11:0]              ring_rdata_a,
  input  logic signed [11:0]              ring_rdata_b,
  output logic                            st_we,
  output logic [$clog2(RING_DEPTH)-1:0]   st_addr,
  output logic signed [11:0]              st_data
);

  localparam int AW = $clog2(RING_DEPTH);
  localparam int SW = $clog2(SINE_TABLE_DEPTH);
  localparam int KW = 16 + SW + 1;
  localparam int PW = AW + 16;
  localparam logic [AW-1:0] LAST_POS = AW'(RING_DEPTH - 1);
  localparam logic [PW:0]   SPAN     = (PW + 1)'(RING_DEPTH) << 16;

  pass_state_t state, state_next;
  logic        issue;
  logic [8:1]  valid;

  logic [AW-1:0] pos;
  logic [15:0]   turn;
  logic [AW-1:0] wcnt;
  logic [PW-1:0] phase;

  // Stage registers.
  logic signed [15:0] sine_q;
  logic signed [32:0] ds_prod;
  logic [16:0]        factor;
  logic [17:0]        step;
  logic [15:0]        frac5;
  logic signed [11:0] a6;
  logic signed [29:0] prodf;
  logic signed [29:0] acc;
  logic signed [40:0] prodg;

  // Combinational values between the stages.
  logic [KW-1:0]      kprod;
  logic signed [32:0] dsa, dsb, dadj;
  logic signed [17:0] m;
  logic signed [18:0] fsum;
  logic [25:0]        pf_prod;
  logic [PW:0]        phase_sum, phase_wrap;
  logic [PW-1:0]      phase_next;
  logic [AW-1:0]      j, jn;
  logic signed [12:0] diff;
  logic signed [29:0] fx, dx;
  logic signed [40:0] gx, gg, adj;
  logic signed [16:0] vq;

  assign kprod = KW'(turn) * KW'(SINE_TABLE_DEPTH);

  psr_sine_rom #(
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
  ) u_sine (
    .clk  (clk),
    .addr (kprod[16 +: SW]),
    .data (sine_q)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      PASS_IDLE: begin
        if (kick) begin
          state_next = PASS_ISSUE;
        end
      end
      PASS_ISSUE: begin
        if (pos == LAST_POS) begin
          state_next = PASS_DRAIN;
        end
      end
      PASS_DRAIN: begin
        if (valid == '0) begin
          state_next = PASS_IDLE;
        end
      end
      default: state_next = PASS_IDLE;
    endcase
  end

  always_comb begin
    issue     = 1'b0;
    stat.busy = 1'b1;
    stat.done = 1'b0;
    unique case (state)
      PASS_IDLE:  stat.busy = 1'b0;
      PASS_ISSUE: issue = 1'b1;
      PASS_DRAIN: stat.done = (valid == '0);
      default:    stat.busy = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= PASS_IDLE;
      valid <= '0;
      phase <= '0;
      pos   <= '0;
      turn  <= '0;
      wcnt  <= '0;
    end else begin
      state <= state_next;
      valid <= {valid[7:1], issue};
      if (kick) begin
        pos  <= '0;
        turn <= '0;
        wcnt <= '0;
      end else begin
        if (issue) begin
          pos  <= pos + 1'b1;
          turn <= turn + cfg.vibrato_step;
        end
        if (valid[8]) begin
          wcnt <= wcnt + 1'b1;
        end
      end
      // The phase carries over from one pass to the next.
      if (valid[4]) begin
        phase <= phase_next;
      end
    end
  end

  always_comb begin
    dsa  = {17'b0, cfg.vibrato_depth};
    dsb  = {{17{sine_q[15]}}, sine_q};
    // Division by 2^15 rounds toward zero, so negative products get a bias.
    dadj = ds_prod + (ds_prod[32] ? 33'sd32767 : 33'sd0);
    m    = dadj[32:15];
    fsum = {m[17], m} + 19'sd65536;

    pf_prod = {17'b0, cfg.pitch_factor} * {9'b0, factor};

    phase_sum  = {1'b0, phase} + (PW + 1)'(step);
    phase_wrap = (phase_sum >= SPAN) ? (phase_sum - SPAN) : phase_sum;
    phase_next = phase_wrap[PW-1:0];
    j          = phase_next[16 +: AW];
    jn         = (j == LAST_POS) ? '0 : j + 1'b1;

    diff = {ring_rdata_b[11], ring_rdata_b} - {ring_rdata_a[11], ring_rdata_a};
    fx   = {14'b0, frac5};
    dx   = {{17{diff[12]}}, diff};

    gx  = {{11{acc[29]}}, acc};
    gg  = {31'b0, cfg.output_gain};
    adj = prodg + (prodg[40] ? 41'sd16777215 : 41'sd0);
    vq  = adj[40:24];
  end

  assign ring_raddr_a = j;
  assign ring_raddr_b = jn;

  always_ff @(posedge clk) begin
    ds_prod <= dsa * dsb;
    factor  <= fsum[16:0];
    step    <= pf_prod[25:8];
    frac5   <= phase_next[15:0];
    a6      <= ring_rdata_a;
    prodf   <= fx * dx;
    acc     <= {{2{a6[11]}}, a6, 16'b0} + prodf;
    prodg   <= gx * gg;
  end

  always_comb begin
    if (vq > 17'sd2047) begin
      st_data = 12'sd2047;
    end else if (vq < -17'sd2048) begin
      st_data = -12'sd2048;
    end else begin
      st_data = vq[11:0];
    end
  end

  assign st_we   = valid[8];
  assign st_addr = wcnt;

endmodule

>>> sv/pitch_shift_resampler.sv
// Top level of the pitch shift resampler: config registers, per-word item path
// and output store. Depends on psr_pkg, psr_ring and psr_pass.
`timescale 1ns / 1ps

// An input word is taken when start is high and busy is low; its 8-bit DAC
// value shows on dac_value with done high for one cycle, registered through
// item_v and done, and cannot be held off. busy stays high for the cycle
// after every accept. The word that fills the last ring slot plays its own
// sample and starts a block pass that refills the output store through a
// pipeline taking one store position per cycle: busy then stays high until
// that pass has drained. Until the first pass has run, every other word
// plays midscale (128). The config registers are not guarded, so write them
// only while busy is low; a running pass reads them as it goes.
module pitch_shift_resampler
  import psr_pkg::*;
#(
  parameter int RING_DEPTH       = RING_DEPTH_DEF,
  parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [11:0]       adc_sample,
  output logic              done,
  output logic [7:0]        dac_value,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [CFG_DW-1:0] cfg_data
);

  localparam int AW = $clog2(RING_DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(RING_DEPTH - 1);

  psr_cfg_t       cfg;
  psr_pass_stat_t pstat;

  logic               accept;
  logic               wrap;
  logic [AW-1:0]      wr_index;
  logic               filled;
  logic               item_v;
  logic               item_wrap;
  logic [7:0]         item_direct;
  logic signed [11:0] centered;

  logic [AW-1:0]      ring_raddr_a, ring_raddr_b;
  logic signed [11:0] ring_rdata_a, ring_rdata_b;

  logic               st_we;
  logic [AW-1:0]      st_addr;
  logic signed [11:0] st_data;
  logic signed [11:0] store_mem [RING_DEPTH];
  logic signed [11:0] store_q;

  assign busy     = rst | item_v | pstat.busy;
  assign accept   = start & ~busy;
  assign wrap     = (wr_index == LAST_IDX);
  assign centered = signed'({~adc_sample[11], adc_sample[10:0]});

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pitch_factor  <= PITCH_FACTOR_RST;
      cfg.vibrato_step  <= VIBRATO_STEP_RST;
      cfg.vibrato_depth <= VIBRATO_DEPTH_RST;
      cfg.output_gain   <= OUTPUT_GAIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PITCH_FACTOR:  cfg.pitch_factor  <= cfg_data[8:0];
        REG_VIBRATO_STEP:  cfg.vibrato_step  <= cfg_data[15:0];
        REG_VIBRATO_DEPTH: cfg.vibrato_depth <= cfg_data[15:0];
        REG_OUTPUT_GAIN:   cfg.output_gain   <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  psr_ring #(
    .RING_DEPTH(RING_DEPTH)
  ) u_ring (
    .clk     (clk),
    .we      (accept),
    .waddr   (wr_index),
    .wdata   (centered),
    .raddr_a (ring_raddr_a),
    .raddr_b (ring_raddr_b),
    .rdata_a (ring_rdata_a),
    .rdata_b (ring_rdata_b)
  );

  psr_pass #(
    .RING_DEPTH       (RING_DEPTH),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_pass (
    .clk          (clk),
    .rst          (rst),
    .kick         (accept & wrap),
    .cfg          (cfg),
    .stat         (pstat),
    .ring_raddr_a (ring_raddr_a),
    .ring_raddr_b (ring_raddr_b),
    .ring_rdata_a (ring_rdata_a),
    .ring_rdata_b (ring_rdata_b),
    .st_we        (st_we),
    .st_addr      (st_addr),
    .st_data      (st_data)
  );

  // The pass writes only while busy and items read only while idle, so the
  // two store ports never touch the same entry in one cycle. The play
  // position always equals the ring slot being written.
  always_ff @(posedge clk) begin
    if (st_we) begin
      store_mem[st_addr] <= st_data;
    end
    store_q <= store_mem[wr_index];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_index <= '0;
      filled   <= 1'b0;
      item_v   <= 1'b0;
      done     <= 1'b0;
    end else begin
      item_v <= accept;
      done   <= item_v;
      if (accept) begin
        wr_index <= wrap ? '0 : wr_index + 1'b1;
      end
      if (pstat.done) begin
        filled <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_wrap   <= wrap;
      item_direct <= adc_sample[11:4];
    end
    if (item_v) begin
      if (item_wrap) begin
        dac_value <= item_direct;
      end else if (filled) begin
        dac_value <= {~store_q[11], store_q[10:4]};
      end else begin
        dac_value <= 8'd128;
      end
    end
  end

endmodule

>>> sv/psr_checker.sv
// Port-level checker for the pitch shift resampler, bound to the top level.
// Depends on pitch_shift_resampler_macros.svh.
`timescale 1ns / 1ps
`include "pitch_shift_resampler_macros.svh"

module psr_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       done,
  input logic [7:0] dac_value
);

  logic accept;
  assign accept = start && !busy;

  // A word in flight keeps busy high in the cycle after its accept.
  `PSR_ASSERT_NEXT(a_accept_busy, clk, rst, accept, busy)
  // Every accepted word yields its result on a later done strobe.
  `PSR_ASSERT_NEXT(a_accept_done, clk, rst, accept, ##1 done)
  // One result per word, so strobes never run back to back.
  `PSR_ASSERT_NEXT(a_done_single, clk, rst, done, !done)
  // A result always follows a cycle in which the block was busy with its word.
  `PSR_ASSERT_NOW(a_done_after_busy, clk, rst, done, $past(busy) && !$isunknown(dac_value))

endmodule

bind pitch_shift_resampler psr_checker u_psr_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .done      (done),
  .dac_value (dac_value)
);

>>> tb/pitch_shift_resampler_test.sv
// Self-checking testbench for pitch_shift_resampler: drives ADC words, mirrors
// the ring, the block pass and playback to predict every DAC word, and checks it.
// Depends on psr_pkg and the pitch_shift_resampler RTL.
`timescale 1ns / 1ps

module pitch_shift_resampler_test;
  import psr_pkg::*;

  localparam int RING_LEN = RING_DEPTH_DEF;
  localparam int SINE_LEN = SINE_TABLE_DEPTH_DEF;
  localparam longint PHASE_SPAN = longint'(RING_LEN) << 16;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic [11:0]       adc_sample;
  logic              done;
  logic [7:0]        dac_value;
  logic              cfg_we;
  cfg_reg_t          cfg_index;
  logic [CFG_DW-1:0] cfg_data;

  // Mirror of the block's configuration and state.
  psr_cfg_t   cfg_mirror;
  int         sine_q15 [SINE_LEN];
  int         sample_ring [RING_LEN];
  int         resampled_store [RING_LEN];
  int         fill_pos;
  int         play_pos;
  longint     read_phase_q16;

  logic [7:0] expected_dac [$];
  int         mismatch_count;
  int         gap_odds;

  pitch_shift_resampler uut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .adc_sample (adc_sample),
    .done       (done),
    .dac_value  (dac_value),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #10 clk = ~clk;

  // Sine table entry in Q1.15, polynomial on the folded quarter wave.
  function automatic int vibrato_sine(int k);
    longint q;
    longint p;
    longint x;
    longint x2;
    longint t;
    q = ((longint'(k) << 16) / SINE_LEN) & 64'hFFFF;
    p = q & 16383;
    x = ((q >> 14) & 1) ? (16384 - p) * 2 : p * 2;
    x2 = (x * x) >> 15;
    t = 21167 - ((x2 * 2463) >> 15);
    t = 51472 - ((x2 * t) >> 15);
    t = (x * t) >> 15;
    if (t > 32767) begin
      t = 32767;
    end
    return ((q >> 15) & 1) ? -int'(t) : int'(t);
  endfunction

  // One store entry of a block pass; advances the read phase.
  function automatic int resample_entry(int pos);
    longint turn;
    longint m;
    longint step;
    longint f;
    longint a;
    longint b;
    longint acc;
    longint v;
    int     k;
    int     j;
    turn = (longint'(pos) * longint'(cfg_mirror.vibrato_step)) & 64'hFFFF;
    k = int'((turn * SINE_LEN) >> 16);
    m = (longint'(cfg_mirror.vibrato_depth) * longint'(sine_q15[k])) / 32768;
    step = (longint'(cfg_mirror.pitch_factor) * (65536 + m)) >>> 8;
    read_phase_q16 = (read_phase_q16 % PHASE_SPAN) + step;
    if (read_phase_q16 >= PHASE_SPAN) begin
      read_phase_q16 -= PHASE_SPAN;
    end
    read_phase_q16 %= PHASE_SPAN;
    j = int'(read_phase_q16 >> 16) % RING_LEN;
    f = read_phase_q16 & 64'hFFFF;
    a = sample_ring[j];
    b = sample_ring[(j + 1) % RING_LEN];
    acc = a * 65536 + f * (b - a);
    v = (acc * longint'(cfg_mirror.output_gain)) / (longint'(1) << 24);
    if (v > 2047) begin
      v = 2047;
    end
    if (v < -2048) begin
      v = -2048;
    end
    return int'(v);
  endfunction

  // Updates the mirrored state for one accepted word and returns its DAC value.
  function automatic logic [7:0] predict_dac(logic [11:0] raw);
    int centered;
    int played;
    int i;
    centered = int'(raw) - 2048;
    sample_ring[fill_pos] = centered;
    fill_pos = (fill_pos + 1) % RING_LEN;
    if (fill_pos == 0) begin
      for (i = 0; i < RING_LEN; i++) begin
        resampled_store[i] = resample_entry(i);
      end
      play_pos = 0;
      played = centered;
    end else if (play_pos < RING_LEN) begin
      played = resampled_store[play_pos];
      play_pos++;
    end else begin
      played = centered;
    end
    return 8'((played + 2048) >> 4);
  endfunction

  function automatic logic [11:0] random_sample();
    case ($urandom_range(0, 7))
      0: return 12'h000;
      1: return 12'hFFF;
      2: return 12'(2016 + $urandom_range(0, 64));
      default: return 12'($urandom_range(0, 4095));
    endcase
  endfunction

  // Holds start high until the word is taken, then queues its prediction.
  task automatic send_sample(logic [11:0] raw);
    @(negedge clk);
    start <= 1'b1;
    adc_sample <= raw;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_dac.push_back(predict_dac(raw));
  endtask

  task automatic maybe_pause();
    int n;
    if (gap_odds != 0 && $urandom_range(0, gap_odds - 1) == 0) begin
      n = $urandom_range(1, 19);
      @(negedge clk);
      start <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic send_random_block(int count, bit with_gaps);
    int i;
    for (i = 0; i < count; i++) begin
      if (i % 32 == 0) begin
        gap_odds = with_gaps ? ($urandom_range(0, 2) == 0 ? 0 : $urandom_range(2, 8)) : 0;
      end
      maybe_pause();
      send_sample(random_sample());
    end
  endtask

  // Drains all outstanding words and any block pass still running.
  task automatic wait_idle();
    @(negedge clk);
    start <= 1'b0;
    while (expected_dac.size() != 0) @(posedge clk);
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_register(cfg_reg_t idx, logic [CFG_DW-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_PITCH_FACTOR:  cfg_mirror.pitch_factor  = value[8:0];
      REG_VIBRATO_STEP:  cfg_mirror.vibrato_step  = value[15:0];
      REG_VIBRATO_DEPTH: cfg_mirror.vibrato_depth = value[15:0];
      REG_OUTPUT_GAIN:   cfg_mirror.output_gain   = value[9:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(logic [15:0] pitch, logic [15:0] vib_step,
                                logic [15:0] depth, logic [15:0] gain);
    wait_idle();
    write_register(REG_PITCH_FACTOR, pitch);
    write_register(REG_VIBRATO_STEP, vib_step);
    write_register(REG_VIBRATO_DEPTH, depth);
    write_register(REG_OUTPUT_GAIN, gain);
  endtask

  // Until the first pass the zeroed store plays midscale for every word.
  task automatic test_playback_before_first_pass();
    logic [11:0] patterns [$];
    int i;
    patterns = '{12'h000, 12'hFFF, 12'h800, 12'h7FF, 12'hAAA, 12'h555, 12'h001,
                 12'hFFE, 12'h801, 12'h7FE, 12'h0F0, 12'hF0F, 12'h100, 12'hEFF,
                 12'h400, 12'hC00, 12'h3FF, 12'hBFF, 12'h080, 12'hF7F};
    gap_odds = 3;
    for (i = 0; i < patterns.size(); i++) begin
      maybe_pause();
      send_sample(patterns[i]);
    end
  endtask

  // Reset register values drive the first pass; the wrap word plays directly.
  task automatic test_default_pass();
    send_random_block(RING_LEN + 24, 1'b1);
  endtask

  // Upper data bits beyond each register's width must be dropped. The words
  // run up to the next wrap so that the pass uses these values.
  task automatic test_register_extremes();
    apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_random_block(RING_LEN - fill_pos, 1'b1);
  endtask

  // Plays back the latest pass with no idle cycles between words.
  task automatic test_back_to_back();
    apply_settings(16'($urandom_range(128, 511)), 16'($urandom), 16'($urandom),
                   16'($urandom_range(200, 1023)));
    send_random_block(88, 1'b0);
  endtask

  always @(posedge clk) begin
    logic [7:0] want;
    if (!rst && done) begin
      if (expected_dac.size() == 0) begin
        $error("dac_value: expected none, actual %0d", dac_value);
        mismatch_count++;
      end else begin
        want = expected_dac.pop_front();
        if (dac_value !== want) begin
          $error("dac_value: expected %0d, actual %0d", want, dac_value);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    int i;
    clk = 1'b0;
    rst = 1'b1;
    start = 1'b0;
    adc_sample = '0;
    cfg_we = 1'b0;
    cfg_index = REG_PITCH_FACTOR;
    cfg_data = '0;
    mismatch_count = 0;
    gap_odds = 0;
    cfg_mirror = '{PITCH_FACTOR_RST, VIBRATO_STEP_RST, VIBRATO_DEPTH_RST, OUTPUT_GAIN_RST};
    for (i = 0; i < SINE_LEN; i++) begin
      sine_q15[i] = vibrato_sine(i);
    end
    for (i = 0; i < RING_LEN; i++) begin
      sample_ring[i] = 0;
      resampled_store[i] = 0;
    end
    fill_pos = 0;
    play_pos = 0;
    read_phase_q16 = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_playback_before_first_pass();
    test_default_pass();
    test_register_extremes();
    test_back_to_back();

    wait_idle();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Generous bound: far beyond every word taking its longest gap plus each pass.
  initial begin
    #20ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
